// ===== rtl/core/selective_repeat_window_receiver_top_macros.svh =====
// Assertion macros shared by the window receiver RTL
`ifndef SELECTIVE_REPEAT_WINDOW_RECEIVER_TOP_MACROS_SVH
`define SELECTIVE_REPEAT_WINDOW_RECEIVER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define SRW_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SRW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SRW_ASSERT(lbl, clk, rst, prop, msg)
`define SRW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/srw_pkg.sv =====
// Package: constants, message codes and buffer control type of the window receiver
`timescale 1ns / 1ps
package srw_pkg;

  localparam int WINDOW_DEF   = 4;
  localparam int SEQ_BITS_DEF = 32;
  localparam int LEN_BITS_DEF = 40;

  localparam int FRAME_BYTES  = 1472;
  localparam int HDR_BYTES    = 8;
  localparam int MAX_PAYLOAD  = FRAME_BYTES - HDR_BYTES;
  localparam int PLEN_W       = 11;
  localparam int KIND_W       = 2;

  typedef enum logic [KIND_W-1:0] {
    ACK_WINDOW  = 2'd0,
    ACK_MISSING = 2'd1,
    ACK_FINISH  = 2'd2
  } ack_kind_t;

  typedef enum logic {
    REQ_DATA    = 1'b0,
    REQ_TIMEOUT = 1'b1
  } req_type_t;

  typedef struct packed {
    logic load;
    logic pair;
  } srw_push_t;

endpackage

// ===== rtl/core/srw_in_if.sv =====
// Input channel: arriving packet or receive timeout
`timescale 1ns / 1ps
interface srw_in_if #(
  parameter int SEQ_BITS = srw_pkg::SEQ_BITS_DEF,
  parameter int LEN_BITS = srw_pkg::LEN_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [SEQ_BITS-1:0]       seq_num;
  logic [srw_pkg::PLEN_W-1:0] payload_len;
  logic [LEN_BITS-1:0]       total_len;

  modport source (output valid, req_type, seq_num, payload_len, total_len, input ready);
  modport sink   (input valid, req_type, seq_num, payload_len, total_len, output ready);
endinterface

// ===== rtl/core/srw_out_if.sv =====
// Output channel: acknowledgement and missing-packet request words
`timescale 1ns / 1ps
interface srw_out_if #(
  parameter int WINDOW   = srw_pkg::WINDOW_DEF,
  parameter int SEQ_BITS = srw_pkg::SEQ_BITS_DEF
);
  localparam int CNT_W = $clog2(WINDOW + 1);

  logic                       valid;
  logic                       ready;
  logic [srw_pkg::KIND_W-1:0] ack_kind;
  logic [CNT_W-1:0]           missing_count;
  logic [WINDOW-1:0]          missing_mask;
  logic [SEQ_BITS-1:0]        window_base;
  logic                       is_last;

  modport source (output valid, ack_kind, missing_count, missing_mask, window_base, is_last,
                  input ready);
  modport sink   (input valid, ack_kind, missing_count, missing_mask, window_base, is_last,
                  output ready);
endinterface

// ===== rtl/core/srw_core.sv =====
// Input register, window bookkeeping and result word generation
`timescale 1ns / 1ps
`include "selective_repeat_window_receiver_top_macros.svh"
module srw_core #(
  parameter int WINDOW   = srw_pkg::WINDOW_DEF,
  parameter int SEQ_BITS = srw_pkg::SEQ_BITS_DEF,
  parameter int LEN_BITS = srw_pkg::LEN_BITS_DEF,
  parameter int CNT_W    = $clog2(WINDOW + 1),
  parameter int RW       = srw_pkg::KIND_W + CNT_W + WINDOW + SEQ_BITS + 1
) (
  input  logic               clk,
  input  logic               rst,
  srw_in_if.sink             rx,
  input  logic               pair_ready,
  output srw_pkg::srw_push_t push,
  output logic [RW-1:0]      word0,
  output logic [RW-1:0]      word1
);

  localparam int IDX_W = $clog2(WINDOW);
  localparam logic [srw_pkg::PLEN_W-1:0] MAX_LEN = srw_pkg::PLEN_W'(srw_pkg::MAX_PAYLOAD);

  logic                       v1;
  logic                       t_type;
  logic [SEQ_BITS-1:0]        t_seq;
  logic [srw_pkg::PLEN_W-1:0] t_len;
  logic [LEN_BITS-1:0]        t_total;

  logic [SEQ_BITS-1:0] base;
  logic [WINDOW-1:0]   map;
  logic [CNT_W-1:0]    expected_left;
  logic [LEN_BITS-1:0] bytes;
  logic [LEN_BITS-1:0] file_total;
  logic                total_known;
  logic                finished;

  logic [SEQ_BITS-1:0] base_next;
  logic [WINDOW-1:0]   map_next;
  logic [CNT_W-1:0]    expected_left_next;
  logic [LEN_BITS-1:0] bytes_next;
  logic [LEN_BITS-1:0] file_total_next;
  logic                total_known_next;
  logic                finished_next;

  logic                       fire;
  logic [SEQ_BITS-1:0]        off;
  logic                       hit;
  logic [IDX_W-1:0]           slot;
  logic [WINDOW-1:0]          slot_bit;
  logic                       new_pkt;
  logic                       timeout;
  logic [srw_pkg::PLEN_W-1:0] len_sat;
  logic [LEN_BITS:0]          sum;
  logic [LEN_BITS-1:0]        bytes_add;
  logic                       seq_zero;
  logic [LEN_BITS-1:0]        total_new;
  logic                       known_new;
  logic                       full;
  logic                       done;
  logic [SEQ_BITS-1:0]        base_adv;

  assign fire     = v1 && pair_ready;
  assign rx.ready = !v1 || pair_ready;

  assign off      = t_seq - base;
  assign hit      = off < SEQ_BITS'(WINDOW);
  assign slot     = off[IDX_W-1:0];
  assign slot_bit = WINDOW'(1) << slot;
  assign timeout  = !finished && (t_type == srw_pkg::REQ_TIMEOUT);
  assign new_pkt  = !finished && (t_type == srw_pkg::REQ_DATA) && hit && !map[slot];

  assign len_sat   = (t_len > MAX_LEN) ? MAX_LEN : t_len;
  assign sum       = {1'b0, bytes} + (LEN_BITS + 1)'(len_sat);
  assign bytes_add = sum[LEN_BITS] ? '1 : sum[LEN_BITS-1:0];
  assign seq_zero  = (t_seq == '0);
  assign total_new = seq_zero ? t_total : file_total;
  assign known_new = total_known || seq_zero;
  assign full      = (expected_left == CNT_W'(1));
  assign done      = known_new && (bytes_add >= total_new);
  assign base_adv  = base + SEQ_BITS'(WINDOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      v1 <= 1'b1;
    end else if (fire) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      t_type  <= rx.req_type;
      t_seq   <= rx.seq_num;
      t_len   <= rx.payload_len;
      t_total <= rx.total_len;
    end
  end

  always_comb begin
    base_next          = base;
    map_next           = map;
    expected_left_next = expected_left;
    bytes_next         = bytes;
    file_total_next    = file_total;
    total_known_next   = total_known;
    finished_next      = finished;
    push               = '0;
    word0              = '0;
    word1              = '0;
    if (fire && timeout) begin
      push.load = 1'b1;
      word0     = {srw_pkg::ACK_MISSING, expected_left, ~map, base, 1'b1};
    end else if (fire && new_pkt) begin
      bytes_next       = bytes_add;
      file_total_next  = total_new;
      total_known_next = known_new;
      finished_next    = done;
      if (full) begin
        map_next           = '0;
        expected_left_next = CNT_W'(WINDOW);
        base_next          = base_adv;
        push.load          = 1'b1;
        push.pair          = done;
        word0 = {srw_pkg::ACK_WINDOW, CNT_W'(0), WINDOW'(0), base, !done};
        word1 = {srw_pkg::ACK_FINISH, CNT_W'(0), WINDOW'(0), base_adv, 1'b1};
      end else begin
        map_next           = map | slot_bit;
        expected_left_next = expected_left - CNT_W'(1);
        push.load          = done;
        word0 = {srw_pkg::ACK_FINISH, CNT_W'(0), WINDOW'(0), base, 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base          <= '0;
      map           <= '0;
      expected_left <= CNT_W'(WINDOW);
      bytes         <= '0;
      file_total    <= '0;
      total_known   <= 1'b0;
      finished      <= 1'b0;
    end else begin
      base          <= base_next;
      map           <= map_next;
      expected_left <= expected_left_next;
      bytes         <= bytes_next;
      file_total    <= file_total_next;
      total_known   <= total_known_next;
      finished      <= finished_next;
    end
  end

  `SRW_ASSERT(a_left_tracks_map, clk, rst, (32'(expected_left) + $countones(map)) == WINDOW, "expected_left out of step with received map")
  `SRW_ASSERT_NEXT(a_finished_sticks, clk, rst, finished, finished, "finished flag cleared")
  `SRW_ASSERT(a_silent_after_finish, clk, rst, !(finished && push.load), "message produced after finish")

endmodule

// ===== rtl/core/srw_msg_buf.sv =====
// Two-word result buffer feeding the output channel
`timescale 1ns / 1ps
`include "selective_repeat_window_receiver_top_macros.svh"
module srw_msg_buf #(
  parameter int WINDOW   = srw_pkg::WINDOW_DEF,
  parameter int SEQ_BITS = srw_pkg::SEQ_BITS_DEF,
  parameter int CNT_W    = $clog2(WINDOW + 1),
  parameter int RW       = srw_pkg::KIND_W + CNT_W + WINDOW + SEQ_BITS + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  srw_pkg::srw_push_t push,
  input  logic [RW-1:0]      word0,
  input  logic [RW-1:0]      word1,
  output logic               pair_ready,
  srw_out_if.source          msg
);

  logic [1:0]    cnt;
  logic [RW-1:0] w0;
  logic [RW-1:0] w1;
  logic          take;

  assign take       = (cnt != 2'd0) && msg.ready;
  assign pair_ready = (cnt == 2'd0) || ((cnt == 2'd1) && msg.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (push.load) begin
      cnt <= push.pair ? 2'd2 : 2'd1;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push.load) begin
      w0 <= word0;
      w1 <= word1;
    end else if (take) begin
      w0 <= w1;
    end
  end

  assign msg.valid = (cnt != 2'd0);
  assign {msg.ack_kind, msg.missing_count, msg.missing_mask, msg.window_base, msg.is_last} = w0;

  `SRW_ASSERT(a_cnt_range, clk, rst, cnt != 2'd3, "buffer count out of range")
  `SRW_ASSERT(a_load_has_room, clk, rst, !push.load || pair_ready, "load into full buffer")
  `SRW_ASSERT_NEXT(a_pair_drains, clk, rst, (cnt == 2'd2) && msg.ready, cnt == 2'd1, "second word lost")

endmodule

// ===== rtl/core/selective_repeat_window_receiver_top.sv =====
// Top level of the selective-repeat window receiver
//
//   channel | dir | contents
//   --------+-----+-------------------------------------------------------------
//   rx      | in  | req_type, seq_num, payload_len, total_len (packet or timeout)
//   msg     | out | ack_kind, missing_count, missing_mask, window_base, is_last
//
// One input word is taken every cycle unless a stall on msg backs up to rx;
// result words are registered in the output buffer, and an input that causes two
// messages fills both of its words. The window check, byte count and message build
// are combinational between the input register and the two-word output buffer.
// Synchronous reset clears the window state at once; no clearing pass is needed.
// A stall on msg holds the buffer; rx keeps accepting until the input register fills.
`timescale 1ns / 1ps
module selective_repeat_window_receiver_top #(
  parameter int WINDOW   = srw_pkg::WINDOW_DEF,
  parameter int SEQ_BITS = srw_pkg::SEQ_BITS_DEF,
  parameter int LEN_BITS = srw_pkg::LEN_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  srw_in_if.sink    rx,
  srw_out_if.source msg
);

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int RW    = srw_pkg::KIND_W + CNT_W + WINDOW + SEQ_BITS + 1;

  srw_pkg::srw_push_t push;
  logic [RW-1:0]      word0;
  logic [RW-1:0]      word1;
  logic               pair_ready;

  srw_core #(
    .WINDOW   (WINDOW),
    .SEQ_BITS (SEQ_BITS),
    .LEN_BITS (LEN_BITS),
    .CNT_W    (CNT_W),
    .RW       (RW)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .pair_ready (pair_ready),
    .push       (push),
    .word0      (word0),
    .word1      (word1)
  );

  srw_msg_buf #(
    .WINDOW   (WINDOW),
    .SEQ_BITS (SEQ_BITS),
    .CNT_W    (CNT_W),
    .RW       (RW)
  ) u_msg_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .word0      (word0),
    .word1      (word1),
    .pair_ready (pair_ready),
    .msg        (msg)
  );

endmodule

// ===== sim/tb.sv =====
// Testbench for the selective-repeat window receiver: windows, drops, timeouts and finish
`timescale 1ns / 1ps
module tb;

  localparam int WIN         = srw_pkg::WINDOW_DEF;
  localparam int QUIET_LIMIT = 1000;
  localparam int ITEM_TARGET = 700;

  typedef logic [srw_pkg::SEQ_BITS_DEF-1:0] seq_t;
  typedef logic [srw_pkg::LEN_BITS_DEF-1:0] len_t;
  typedef logic [srw_pkg::PLEN_W-1:0]       plen_t;

  typedef struct packed {
    srw_pkg::ack_kind_t kind;
    logic [2:0]         cnt;
    logic [WIN-1:0]     mask;
    seq_t               base;
    logic               last;
  } ack_word_t;

  class ack_tracker;
    seq_t           base_seq;
    logic [WIN-1:0] got_map;
    len_t           byte_cnt;
    len_t           file_len;
    bit             len_known;
    bit             done;
    int             failures;
    ack_word_t      acks_due[$];

    function new();
      base_seq  = '0;
      got_map   = '0;
      byte_cnt  = '0;
      file_len  = '0;
      len_known = 1'b0;
      done      = 1'b0;
      failures  = 0;
    endfunction

    function bit take_input(srw_pkg::req_type_t req, seq_t seq, plen_t len, len_t tot);
      seq_t           off;
      plen_t          plen;
      logic [WIN-1:0] miss;
      ack_word_t      w[2];
      int             n;
      n = 0;
      if (done) return 1'b0;
      if (req == srw_pkg::REQ_TIMEOUT) begin
        miss = ~got_map;
        acks_due.push_back(ack_word_t'{srw_pkg::ACK_MISSING, 3'($countones(miss)), miss,
                                       base_seq, 1'b1});
        return 1'b1;
      end
      off = seq - base_seq;
      if (off >= seq_t'(WIN)) return 1'b0;
      if (got_map[off]) return 1'b0;
      plen = (len > plen_t'(srw_pkg::MAX_PAYLOAD)) ? plen_t'(srw_pkg::MAX_PAYLOAD) : len;
      if (seq == '0) begin
        file_len  = tot;
        len_known = 1'b1;
      end
      if (~byte_cnt < len_t'(plen)) byte_cnt = '1;
      else byte_cnt = byte_cnt + len_t'(plen);
      got_map[off] = 1'b1;
      if (&got_map) begin
        w[n] = ack_word_t'{srw_pkg::ACK_WINDOW, 3'd0, '0, base_seq, 1'b0};
        n++;
        got_map  = '0;
        base_seq = base_seq + seq_t'(WIN);
      end
      if (len_known && byte_cnt >= file_len) begin
        w[n] = ack_word_t'{srw_pkg::ACK_FINISH, 3'd0, '0, base_seq, 1'b0};
        n++;
        done = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
        w[i].last = (i == n - 1);
        acks_due.push_back(w[i]);
      end
      return 1'b1;
    endfunction

    function void match_ack(ack_word_t got);
      ack_word_t exp;
      if (acks_due.size() == 0) begin
        $error("unexpected word: ack_kind %0d window_base %0d", got.kind, got.base);
        failures++;
        return;
      end
      exp = acks_due.pop_front();
      if (got.kind !== exp.kind) begin
        $error("ack_kind: expected %0d, got %0d", exp.kind, got.kind);
        failures++;
      end
      if (got.cnt !== exp.cnt) begin
        $error("missing_count: expected %0d, got %0d", exp.cnt, got.cnt);
        failures++;
      end
      if (got.mask !== exp.mask) begin
        $error("missing_mask: expected %b, got %b", exp.mask, got.mask);
        failures++;
      end
      if (got.base !== exp.base) begin
        $error("window_base: expected %0d, got %0d", exp.base, got.base);
        failures++;
      end
      if (got.last !== exp.last) begin
        $error("is_last: expected %0d, got %0d", exp.last, got.last);
        failures++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  bit         calm;
  int         quiet_cycles;
  ack_word_t  seen;
  ack_tracker tracker = new();

  srw_in_if  rx_if ();
  srw_out_if msg_if ();

  selective_repeat_window_receiver_top u_top (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .msg (msg_if)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic send_word(input srw_pkg::req_type_t req, input seq_t seq, input plen_t len,
                           input len_t tot, output bit took);
    while (!calm && $urandom_range(99) < 27) begin
      rx_if.valid <= 1'b0;
      @(negedge clk);
    end
    rx_if.valid       <= 1'b1;
    rx_if.req_type    <= req;
    rx_if.seq_num     <= seq;
    rx_if.payload_len <= len;
    rx_if.total_len   <= tot;
    do @(posedge clk); while (!rx_if.ready);
    took = tracker.take_input(req, seq, len, tot);
    @(negedge clk);
  endtask

  function automatic int unsigned open_slot();
    int unsigned s;
    s = $urandom_range(WIN - 1);
    for (int i = 0; i < WIN; i++) begin
      if (!tracker.got_map[(s + i) % WIN]) return (s + i) % WIN;
    end
    return s;
  endfunction

  task automatic random_item(output bit took);
    int unsigned        pick;
    srw_pkg::req_type_t req;
    seq_t               seq;
    plen_t              len;
    len_t               tot;
    pick = $urandom_range(99);
    req  = srw_pkg::REQ_DATA;
    seq  = seq_t'($urandom());
    tot  = len_t'({$urandom(), $urandom()});
    if ($urandom_range(9) == 0) len = plen_t'($urandom_range(2047, srw_pkg::MAX_PAYLOAD + 1));
    else len = plen_t'($urandom_range(srw_pkg::MAX_PAYLOAD));
    if (pick < 10) req = srw_pkg::REQ_TIMEOUT;
    else if (pick < 60) seq = tracker.base_seq + seq_t'(open_slot());
    else if (pick < 80) seq = tracker.base_seq + seq_t'($urandom_range(WIN - 1));
    else if (pick < 87) seq = tracker.base_seq + seq_t'($urandom_range(2 * WIN - 1, WIN));
    else if (pick < 94) seq = tracker.base_seq - seq_t'($urandom_range(WIN, 1));
    send_word(req, seq, len, tot, took);
  endtask

  always @(negedge clk) begin
    msg_if.ready <= calm || ($urandom_range(99) >= 27);
  end

  always @(posedge clk) begin
    if (!rst && msg_if.valid && msg_if.ready) begin
      seen.kind = srw_pkg::ack_kind_t'(msg_if.ack_kind);
      seen.cnt  = msg_if.missing_count;
      seen.mask = msg_if.missing_mask;
      seen.base = msg_if.window_base;
      seen.last = msg_if.is_last;
      tracker.match_ack(seen);
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_if.valid && rx_if.ready) || (msg_if.valid && msg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned done_items;
    bit          took;
    len_t        announced;
    len_t        rem;
    plen_t       len;
    rst               = 1'b1;
    calm              = 1'b0;
    quiet_cycles      = 0;
    rx_if.valid       = 1'b0;
    rx_if.req_type    = srw_pkg::REQ_DATA;
    rx_if.seq_num     = '0;
    rx_if.payload_len = '0;
    rx_if.total_len   = '0;
    msg_if.ready      = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    announced = len_t'(320000 + $urandom_range(40000));
    send_word(srw_pkg::REQ_TIMEOUT, '1, '1, '1, took);
    send_word(srw_pkg::REQ_DATA, seq_t'(2), '1, '1, took);
    send_word(srw_pkg::REQ_DATA, seq_t'(2), plen_t'(100), '0, took);
    send_word(srw_pkg::REQ_DATA, seq_t'(WIN), plen_t'(100), '0, took);
    send_word(srw_pkg::REQ_DATA, '1, plen_t'(100), '0, took);
    send_word(srw_pkg::REQ_DATA, seq_t'(3), plen_t'(srw_pkg::MAX_PAYLOAD + 1), '0, took);
    send_word(srw_pkg::REQ_TIMEOUT, '0, '0, '0, took);
    send_word(srw_pkg::REQ_DATA, '0, '0, announced, took);
    send_word(srw_pkg::REQ_DATA, seq_t'(1), plen_t'(srw_pkg::MAX_PAYLOAD), '1, took);
    send_word(srw_pkg::REQ_TIMEOUT, '0, '0, '0, took);
    send_word(srw_pkg::REQ_DATA, '0, plen_t'(10), '1, took);
    send_word(srw_pkg::REQ_DATA, seq_t'(7), plen_t'(1), '0, took);
    send_word(srw_pkg::REQ_DATA, seq_t'(8), plen_t'(1), '0, took);
    send_word(srw_pkg::REQ_DATA, seq_t'(5), '0, '0, took);
    send_word(srw_pkg::REQ_TIMEOUT, '0, '0, '0, took);
    send_word(srw_pkg::REQ_DATA, seq_t'(4), plen_t'(1), '0, took);
    send_word(srw_pkg::REQ_DATA, seq_t'(6), plen_t'(1), '0, took);

    done_items = 0;
    while (done_items < ITEM_TARGET &&
           tracker.file_len - tracker.byte_cnt > len_t'(4 * srw_pkg::MAX_PAYLOAD)) begin
      calm = (done_items >= 200 && done_items < 320);
      random_item(took);
      done_items++;
    end
    calm = 1'b0;

    // hold each window short of the total until its last slot lands
    while (!tracker.done) begin
      rem = tracker.file_len - tracker.byte_cnt;
      if (rem > len_t'(srw_pkg::MAX_PAYLOAD)) len = plen_t'(srw_pkg::MAX_PAYLOAD);
      else if ($countones(tracker.got_map) == WIN - 1) len = plen_t'(rem);
      else len = plen_t'(rem - 1);
      send_word(srw_pkg::REQ_DATA, tracker.base_seq + seq_t'(open_slot()), len,
                len_t'({$urandom(), $urandom()}), took);
    end

    repeat (6) random_item(took);
    rx_if.valid <= 1'b0;

    while (tracker.acks_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
